// File: hw/rtl/lis_pkg.sv
// ----------------------------------------------------------------------------
// lis_pkg
// Shared types and constants for the longest increasing subsequence block.
// ----------------------------------------------------------------------------
`default_nettype none

package lis_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned OUT_LEN_W = 11;

  // one element of the sequence as it arrives
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      first;
  } in_t;

  // one result per element
  typedef struct packed {
    logic [OUT_LEN_W-1:0] end_length;
    logic [OUT_LEN_W-1:0] best_length;
    logic                 overflow;
  } out_t;

  // queued item: value turned into an unsigned-ordered key
  typedef struct packed {
    logic [VALUE_W-1:0] key;
    logic               first;
  } item_t;

  localparam logic [VALUE_W-1:0] SIGN_FLIP = {1'b1, {(VALUE_W-1){1'b0}}};

endpackage

`default_nettype wire

// File: hw/rtl/lis_ram.sv
// ----------------------------------------------------------------------------
// lis_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lis_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lis_front.sv
// ----------------------------------------------------------------------------
// lis_front
// Accepts input elements, forms the ordered key and holds them in a
// two-entry queue ahead of the scan engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lis_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output      logic            item_ready,
  input  wire lis_pkg::in_t    item,
  output      logic            q_valid,
  input  wire logic            q_ready,
  output      lis_pkg::item_t  q_item
);

  lis_pkg::item_t slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  logic           push;
  logic           pop;

  assign item_ready = (fill != 2'd2);
  assign q_valid    = (fill != 2'd0);
  assign q_item     = slot[rd_ptr];
  assign push       = item_valid && item_ready;
  assign pop        = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        // flipping the sign bit makes unsigned order match signed order
        slot[wr_ptr].key   <= item.value ^ lis_pkg::SIGN_FLIP;
        slot[wr_ptr].first <= item.first;
        wr_ptr             <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= 2'd2)
    else $error("queue fill out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd1) |-> (wr_ptr != rd_ptr))
    else $error("queue pointers disagree with fill");
  a_ptr_same: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd0 || fill == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with fill");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/lis_back.sv
// ----------------------------------------------------------------------------
// lis_back
// Scan engine: walks the stored elements of the current sequence one per
// cycle, keeps the best predecessor length, stores the new element and
// presents the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lis_back #(
  parameter int unsigned MAX_ELEMENTS = 1024
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            allow_equal,
  input  wire logic            q_valid,
  output      logic            q_ready,
  input  wire lis_pkg::item_t  q_item,
  output      logic            result_valid,
  input  wire logic            result_ready,
  output      lis_pkg::out_t   result
);

  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned KW = lis_pkg::VALUE_W;
  localparam int unsigned DW = KW + CW;
  localparam int unsigned OW = lis_pkg::OUT_LEN_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_WRITE = 3'b100
  } state_t;

  state_t         state;
  logic [CW-1:0]  count;
  logic [CW-1:0]  best;
  logic [CW-1:0]  idx;
  logic [CW-1:0]  len_r;
  logic [KW-1:0]  key_r;
  logic           pend;

  logic           pop;
  logic [CW-1:0]  count_eff;
  logic [CW-1:0]  best_eff;
  logic [CW-1:0]  best_next;
  logic           rd_en;
  logic [DW-1:0]  rd_data;
  logic [KW-1:0]  rd_key;
  logic [CW-1:0]  rd_len;
  logic [CW-1:0]  cand;
  logic           precede;

  assign q_ready   = (state == S_IDLE) && !result_valid;
  assign pop       = q_valid && q_ready;
  assign count_eff = q_item.first ? '0 : count;
  assign best_eff  = q_item.first ? '0 : best;
  assign best_next = (len_r > best) ? len_r : best;

  assign rd_en   = (state == S_SCAN) && (idx != count);
  assign rd_key  = rd_data[DW-1 -: KW];
  assign rd_len  = rd_data[CW-1:0];
  assign cand    = rd_len + CW'(1);
  assign precede = allow_equal ? (rd_key <= key_r) : (rd_key < key_r);

  lis_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (state == S_WRITE),
    .wr_addr (count[AW-1:0]),
    .wr_data ({key_r, len_r}),
    .rd_en   (rd_en),
    .rd_addr (idx[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      best         <= '0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            key_r <= q_item.key;
            len_r <= CW'(1);
            idx   <= '0;
            pend  <= 1'b0;
            if (q_item.first) begin
              count <= '0;
              best  <= '0;
            end
            if (count_eff >= CW'(MAX_ELEMENTS)) begin
              // store full: report and leave the sequence as it is
              result_valid       <= 1'b1;
              result.end_length  <= '0;
              result.best_length <= OW'(best_eff);
              result.overflow    <= 1'b1;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // read data is registered, so it arrives in the cycle after its address
          if (pend && precede && (cand > len_r)) begin
            len_r <= cand;
          end
          if (idx != count) begin
            idx  <= idx + CW'(1);
            pend <= 1'b1;
          end else begin
            pend  <= 1'b0;
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          count              <= count + CW'(1);
          best               <= best_next;
          result_valid       <= 1'b1;
          result.end_length  <= OW'(len_r);
          result.best_length <= OW'(best_next);
          result.overflow    <= 1'b0;
          state              <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ELEMENTS))
    else $error("element count above capacity");
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> ({1'b0, len_r} <= ({1'b0, count} + (CW+1)'(1))))
    else $error("running length exceeds stored elements plus one");
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> !result_valid)
    else $error("result register busy at write");
  a_best_covers: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |=> (best >= $past(len_r)))
    else $error("best length below end length");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/longest_increasing_subsequence.sv
// ----------------------------------------------------------------------------
// longest_increasing_subsequence
// Streaming longest increasing subsequence length, quadratic scan over the
// stored elements of the current sequence.
//
//   channel  dir  handshake              payload
//   item     in   item_valid/ready       lis_pkg::in_t  (value, first)
//   result   out  result_valid/ready     lis_pkg::out_t (end, best, overflow)
//   cfg      in   cfg_valid/ready        cfg_allow_equal
//
// The scan engine reads the stored predecessors of an element one entry
// per cycle through the single read port of the element store, then
// writes the element. A full store answers without a scan.
// The engine takes its next element in the cycle after the result is accepted.
// Reset is synchronous and empties the queue and the sequence.
// A two-entry queue keeps taking elements while a result waits, until it
// is full; the engine holds while the result register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_increasing_subsequence #(
  parameter int unsigned MAX_ELEMENTS = 1024
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output      logic           item_ready,
  input  wire lis_pkg::in_t   item,
  output      logic           result_valid,
  input  wire logic           result_ready,
  output      lis_pkg::out_t  result,
  input  wire logic           cfg_valid,
  output      logic           cfg_ready,
  input  wire logic           cfg_allow_equal
);

  logic           allow_equal;
  logic           q_valid;
  logic           q_ready;
  lis_pkg::item_t q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_equal <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      allow_equal <= cfg_allow_equal;
    end
  end

  lis_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item)
  );

  lis_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .allow_equal  (allow_equal),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire
